// File: rtl/core/tkeo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkeo_pkg
// Shared constants and types for the Teager-Kaiser energy disturbance
// detector: field widths, register indexes, register reset values and the
// detector state encoding.
// ----------------------------------------------------------------------------
package tkeo_pkg;

   // Sample width default and fixed field widths
   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int ENERGY_W             = 33;
   localparam int MAG_REG_W            = 16;
   localparam int QRUN_W               = 16;
   localparam int CSR_DATA_W           = 33;
   localparam int CSR_IDX_W            = 3;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENERGY_HIGH     = 3'd0,
      REG_ENERGY_LOW      = 3'd1,
      REG_ONSET_MAGNITUDE = 3'd2,
      REG_QUIET_MAGNITUDE = 3'd3,
      REG_QUIET_DEBOUNCE  = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic signed [ENERGY_W-1:0] ENERGY_HIGH_RST     = 33'sd4096;
   localparam logic signed [ENERGY_W-1:0] ENERGY_LOW_RST      = 33'sd1024;
   localparam logic [MAG_REG_W-1:0]       ONSET_MAGNITUDE_RST = 16'd800;
   localparam logic [MAG_REG_W-1:0]       QUIET_MAGNITUDE_RST = 16'd400;
   localparam logic [QRUN_W-1:0]          QUIET_DEBOUNCE_RST  = 16'd10;

   // Schmitt detector states, one-hot
   typedef enum logic [1:0] {
      DET_IDLE      = 2'b01,
      DET_DISTURBED = 2'b10
   } det_state_type;

endpackage : tkeo_pkg
`default_nettype wire

// File: rtl/core/tkeo_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkeo_if
// Valid/ready channels of the detector: the sample request channel and the
// energy/state response channel.
// ----------------------------------------------------------------------------
interface tkeo_req_if #(
   parameter int SAMPLE_WIDTH = tkeo_pkg::SAMPLE_WIDTH_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] magnitude;
   logic                    restart;

   modport source (output valid, output magnitude, output restart, input ready);
   modport sink   (input valid, input magnitude, input restart, output ready);
endinterface : tkeo_req_if

interface tkeo_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tkeo_pkg::ENERGY_W-1:0]  energy;
   logic                                  energy_valid;
   logic                                  disturbed;

   modport source (output valid, output energy, output energy_valid, output disturbed,
                   input ready);
   modport sink   (input valid, input energy, input energy_valid, input disturbed,
                   output ready);
endinterface : tkeo_rsp_if
`default_nettype wire

// File: rtl/core/tkeo_hysteresis_disturbance_detector_top.sv
`default_nettype none
// A word accepted on the sample channel is held in the window register, then
// in the result register, which offers it on the response channel. One word
// per cycle is taken while the response channel does not stall; the multiply,
// compare and detector update between the two stages are combinational.
// Reset (synchronous, active high) empties the window, sets the detector idle
// and loads the register defaults 4096, 1024, 800, 400 and 10.
// ----------------------------------------------------------------------------
// tkeo_hysteresis_disturbance_detector_top
// Three-sample Teager-Kaiser energy x1*x1 - x0*x2 with a two-state Schmitt
// disturbance detector and a saturating quiet-run debounce.
// ----------------------------------------------------------------------------
module tkeo_hysteresis_disturbance_detector_top #(
   parameter int SAMPLE_WIDTH = tkeo_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tkeo_req_if.sink                                 req_ch,
   tkeo_rsp_if.source                               rsp_ch,
   input  wire logic                                csr_wr_en,
   input  wire logic [tkeo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tkeo_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import tkeo_pkg::*;

   localparam int PROD_W = (2 * SAMPLE_WIDTH > ENERGY_W) ? 2 * SAMPLE_WIDTH : ENERGY_W;
   localparam int CMP_W  = (SAMPLE_WIDTH > MAG_REG_W) ? SAMPLE_WIDTH : MAG_REG_W;

   // Configuration registers
   logic signed [ENERGY_W-1:0] energy_high_ff;
   logic signed [ENERGY_W-1:0] energy_low_ff;
   logic [MAG_REG_W-1:0]       onset_mag_ff;
   logic [MAG_REG_W-1:0]       quiet_mag_ff;
   logic [QRUN_W-1:0]          quiet_db_ff;

   // Window stage
   logic [SAMPLE_WIDTH-1:0]    win_ff [3];
   logic [1:0]                 fill_count_ff;
   logic                       s1_valid_ff;
   logic                       s1_restart_ff;
   logic                       s1_full_ff;

   // Detector and result stage
   det_state_type              det_ff, det_in;
   logic [QRUN_W-1:0]          qrun_ff, qrun_in;
   logic                       rsp_valid_ff;
   logic signed [ENERGY_W-1:0] rsp_energy_ff;
   logic                       rsp_energy_valid_ff;
   logic                       rsp_disturbed_ff;

   logic                       req_fire;
   logic                       advance;

   logic [2*SAMPLE_WIDTH-1:0]  sq_term;
   logic [2*SAMPLE_WIDTH-1:0]  cross_term;
   logic [PROD_W-1:0]          diff;
   logic signed [ENERGY_W-1:0] energy;
   logic [CMP_W-1:0]           mag_ext;
   logic                       loud;
   logic                       quiet;
   logic                       trigger;
   logic [QRUN_W-1:0]          qrun_step;

   // Handshake: stage 1 moves on when the result register is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         energy_high_ff <= ENERGY_HIGH_RST;
         energy_low_ff  <= ENERGY_LOW_RST;
         onset_mag_ff   <= ONSET_MAGNITUDE_RST;
         quiet_mag_ff   <= QUIET_MAGNITUDE_RST;
         quiet_db_ff    <= QUIET_DEBOUNCE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENERGY_HIGH:     energy_high_ff <= $signed(csr_wr_data[ENERGY_W-1:0]);
            REG_ENERGY_LOW:      energy_low_ff  <= $signed(csr_wr_data[ENERGY_W-1:0]);
            REG_ONSET_MAGNITUDE: onset_mag_ff   <= csr_wr_data[MAG_REG_W-1:0];
            REG_QUIET_MAGNITUDE: quiet_mag_ff   <= csr_wr_data[MAG_REG_W-1:0];
            REG_QUIET_DEBOUNCE:  quiet_db_ff    <= csr_wr_data[QRUN_W-1:0];
            default: ;
         endcase
      end
   end

   // Window fill and shift on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fill_count_ff <= 2'd0;
      end else begin
         s1_valid_ff <= req_fire || (s1_valid_ff && !advance);
         if (req_fire) begin
            s1_restart_ff <= req_ch.restart;
            if (req_ch.restart) begin
               fill_count_ff <= 2'd0;
               s1_full_ff    <= 1'b0;
            end else if (fill_count_ff != 2'd3) begin
               case (fill_count_ff)
                  2'd0:    win_ff[0] <= req_ch.magnitude;
                  2'd1:    win_ff[1] <= req_ch.magnitude;
                  default: win_ff[2] <= req_ch.magnitude;
               endcase
               fill_count_ff <= fill_count_ff + 2'd1;
               s1_full_ff    <= (fill_count_ff == 2'd2);
            end else begin
               win_ff[0]  <= win_ff[1];
               win_ff[1]  <= win_ff[2];
               win_ff[2]  <= req_ch.magnitude;
               s1_full_ff <= 1'b1;
            end
         end
      end
   end

   // Energy: products wrap into 33 bits as two's complement
   always_comb begin
      sq_term    = win_ff[1] * win_ff[1];
      cross_term = win_ff[0] * win_ff[2];
      diff       = PROD_W'(sq_term) - PROD_W'(cross_term);
      energy     = $signed(diff[ENERGY_W-1:0]);
   end

   // Loud/quiet classification; the newest sample is the magnitude
   always_comb begin
      mag_ext = CMP_W'(win_ff[2]);
      trigger = (energy > energy_high_ff) || (mag_ext > CMP_W'(onset_mag_ff));
      loud    = (energy > energy_high_ff) || (mag_ext >= CMP_W'(quiet_mag_ff));
      quiet   = (energy < energy_low_ff) && (mag_ext < CMP_W'(quiet_mag_ff));
   end

   // Schmitt detector with saturating quiet-run debounce
   always_comb begin
      det_in    = det_ff;
      qrun_in   = qrun_ff;
      qrun_step = (qrun_ff < quiet_db_ff) ? qrun_ff + 1'b1 : qrun_ff;
      if (s1_restart_ff) begin
         det_in  = DET_IDLE;
         qrun_in = '0;
      end else if (s1_full_ff) begin
         case (det_ff)
            DET_IDLE: begin
               if (trigger) begin
                  det_in  = DET_DISTURBED;
                  qrun_in = '0;
               end
            end
            DET_DISTURBED: begin
               if (qrun_ff != '0) begin
                  if (loud) begin
                     qrun_in = '0;
                  end else if (quiet) begin
                     if (qrun_step >= quiet_db_ff) begin
                        det_in  = DET_IDLE;
                        qrun_in = '0;
                     end else begin
                        qrun_in = qrun_step;
                     end
                  end
               end else begin
                  qrun_in = quiet ? QRUN_W'(1) : '0;
               end
            end
            default: begin
               det_in  = DET_IDLE;
               qrun_in = '0;
            end
         endcase
      end
   end

   // Detector state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         det_ff       <= DET_IDLE;
         qrun_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ch.ready);
         if (advance) begin
            det_ff              <= det_in;
            qrun_ff             <= qrun_in;
            rsp_energy_ff       <= s1_full_ff && !s1_restart_ff ? energy : '0;
            rsp_energy_valid_ff <= s1_full_ff && !s1_restart_ff;
            rsp_disturbed_ff    <= (det_in == DET_DISTURBED);
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.energy       = rsp_energy_ff;
   assign rsp_ch.energy_valid = rsp_energy_valid_ff;
   assign rsp_ch.disturbed    = rsp_disturbed_ff;

`ifndef SYNTH
   // Energy reads zero until the window is full
   a_energy_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_energy_valid_ff |-> rsp_energy_ff == '0)
      else $error("energy not zero while window filling");

   // A quiet run only exists in the disturbed state
   a_qrun_state: assert property (@(posedge clock) disable iff (reset)
      qrun_ff != '0 |-> det_ff == DET_DISTURBED)
      else $error("quiet run counting while idle");

   // A restart word empties the window
   a_restart_fill: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.restart |=> fill_count_ff == 2'd0)
      else $error("window not cleared by restart");

   // A stalled window-stage word is held, not lost
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("window-stage word dropped");
`endif

endmodule : tkeo_hysteresis_disturbance_detector_top
`default_nettype wire

// File: verif/tkeo_hysteresis_disturbance_detector_top_test.sv
// ----------------------------------------------------------------------------
// tkeo_hysteresis_disturbance_detector_top_test
// Self-checking bench for the Teager-Kaiser energy disturbance detector.
// A short table of directed sample words, some with hand-typed results, is
// followed by random phases under several register settings, the extremes
// among them. Random idling is applied on both channels. Every result word is
// checked with its hand-typed result or the bench's window/detector model.
// ----------------------------------------------------------------------------
module tkeo_hysteresis_disturbance_detector_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tkeo_pkg::*;

   localparam int CLK_PERIOD      = 4;
   localparam int RESET_CYCLES    = 11;
   localparam int SAMPLE_W        = 16;
   localparam int PIPE_LATENCY    = 2;
   localparam int STALL_LIMIT     = 1000;
   localparam int WORDS_PER_PHASE = 90;

   // Largest energy magnitude for 16-bit samples
   localparam logic signed [ENERGY_W-1:0] TKEO_PEAK = 33'sd4294836225;
   localparam logic [SAMPLE_W-1:0]        MAG_MAX   = 16'hFFFF;

   // Indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [ENERGY_W-1:0] energy;
      logic                       energy_valid;
      logic                       disturbed;
   } tkeo_word_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [SAMPLE_W-1:0]    mag;
      logic                   restart;
      logic [CSR_IDX_W-1:0]   reg_idx;
      longint                 reg_val;
      logic                   pinned;
      tkeo_word_type          want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   tkeo_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_ch ();
   tkeo_rsp_if                            rsp_ch ();

   tkeo_hysteresis_disturbance_detector_top #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Model state: sample window, detector and registers
   logic [SAMPLE_W-1:0]  win [3];
   int unsigned          fill_cnt;
   det_state_type        det_state;
   logic [QRUN_W-1:0]    quiet_run;
   longint               high_thr;
   longint               low_thr;
   logic [MAG_REG_W-1:0] onset_thr;
   logic [MAG_REG_W-1:0] quiet_thr;
   logic [QRUN_W-1:0]    debounce_len;

   tkeo_word_type energy_backlog [$];
   int            mismatch_count = 0;
   int unsigned   quiet_cycles   = 0;

   // Hand-typed result for the word being driven
   logic          pin_now  = 1'b0;
   tkeo_word_type pin_word = '0;

   // Values of the current phase, used to shape the random words
   int unsigned ph_onset;
   int unsigned ph_quiet;
   int unsigned ph_debounce;

   function automatic void clear_window();
      win[0]    = '0;
      win[1]    = '0;
      win[2]    = '0;
      fill_cnt  = 0;
      det_state = DET_IDLE;
      quiet_run = '0;
   endfunction

   // Short gaps mostly, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(99);
      if (r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Model and checker, both on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      longint              nrg;
      logic                quiet;
      logic [SAMPLE_W-1:0] mag;
      tkeo_word_type       got;
      tkeo_word_type       want;
      if (reset) begin
         clear_window();
         high_thr     = longint'(ENERGY_HIGH_RST);
         low_thr      = longint'(ENERGY_LOW_RST);
         onset_thr    = ONSET_MAGNITUDE_RST;
         quiet_thr    = QUIET_MAGNITUDE_RST;
         debounce_len = QUIET_DEBOUNCE_RST;
         energy_backlog.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               REG_ENERGY_HIGH:     high_thr     = longint'($signed(csr_wr_data));
               REG_ENERGY_LOW:      low_thr      = longint'($signed(csr_wr_data));
               REG_ONSET_MAGNITUDE: onset_thr    = csr_wr_data[MAG_REG_W-1:0];
               REG_QUIET_MAGNITUDE: quiet_thr    = csr_wr_data[MAG_REG_W-1:0];
               REG_QUIET_DEBOUNCE:  debounce_len = csr_wr_data[QRUN_W-1:0];
               default: ;
            endcase
         end

         // returned word against the oldest outstanding one
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.energy, rsp_ch.energy_valid, rsp_ch.disturbed};
            if (energy_backlog.size() == 0) begin
               $error("result word with nothing outstanding: energy %0d", got.energy);
               mismatch_count++;
            end else begin
               want = energy_backlog.pop_front();
               if (got.energy !== want.energy) begin
                  $error("energy: expected %0d, got %0d", want.energy, got.energy);
                  mismatch_count++;
               end
               if (got.energy_valid !== want.energy_valid) begin
                  $error("energy_valid: expected %0b, got %0b",
                         want.energy_valid, got.energy_valid);
                  mismatch_count++;
               end
               if (got.disturbed !== want.disturbed) begin
                  $error("disturbed: expected %0b, got %0b", want.disturbed, got.disturbed);
                  mismatch_count++;
               end
            end
         end

         // accepted sample word: advance the window and the detector
         if (req_ch.valid && req_ch.ready) begin
            want = '0;
            mag  = req_ch.magnitude;
            if (req_ch.restart) begin
               clear_window();
            end else begin
               if (fill_cnt < 3) begin
                  win[fill_cnt] = mag;
                  fill_cnt++;
               end else begin
                  win[0] = win[1];
                  win[1] = win[2];
                  win[2] = mag;
               end
               if (fill_cnt < 3) begin
                  // window still filling: detector holds
                  want.disturbed = (det_state == DET_DISTURBED);
               end else begin
                  nrg   = longint'(win[1]) * longint'(win[1])
                        - longint'(win[0]) * longint'(win[2]);
                  quiet = (nrg < low_thr) && (mag < quiet_thr);
                  if (det_state == DET_IDLE) begin
                     if ((nrg > high_thr) || (mag > onset_thr)) begin
                        det_state = DET_DISTURBED;
                        quiet_run = '0;
                     end
                  end else if (quiet_run != '0) begin
                     if ((nrg > high_thr) || (mag >= quiet_thr)) begin
                        quiet_run = '0;
                     end else if (quiet) begin
                        if (quiet_run < debounce_len) begin
                           quiet_run++;
                        end
                        if (quiet_run >= debounce_len) begin
                           det_state = DET_IDLE;
                           quiet_run = '0;
                        end
                     end
                  end else begin
                     quiet_run = quiet ? QRUN_W'(1) : '0;
                  end
                  want.energy       = nrg[ENERGY_W-1:0];
                  want.energy_valid = 1'b1;
                  want.disturbed    = (det_state == DET_DISTURBED);
               end
            end
            energy_backlog.push_back(pin_now ? pin_word : want);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without a word moving on either channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Result side back-pressure
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      int unsigned r;
      int unsigned span;
      logic        level;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         r = $urandom_range(99);
         if (r < 15) begin
            level = 1'b1;
            span  = $urandom_range(30, 80);
         end else if (r < 60) begin
            level = 1'b1;
            span  = $urandom_range(1, 8);
         end else if (r < 90) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else begin
            level = 1'b0;
            span  = $urandom_range(10, 40);
         end
         repeat (span) begin
            @(negedge clock);
            rsp_ch.ready <= level;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sample channel and register port drivers
   // ------------------------------------------------------------------------
   task automatic send_word(logic [SAMPLE_W-1:0] mag, logic rst, int unsigned gap,
                            logic pin, tkeo_word_type pinned);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.magnitude <= mag;
      req_ch.restart   <= rst;
      pin_now          <= pin;
      pin_word         <= pinned;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop sending and wait until every result word is back
   task automatic pause_stream();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (energy_backlog.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic program_detector(longint hi, longint lo, int unsigned onset,
                                   int unsigned qmag, int unsigned deb);
      pause_stream();
      write_reg(REG_ENERGY_HIGH, hi);
      write_reg(REG_ENERGY_LOW, lo);
      write_reg(REG_ONSET_MAGNITUDE, onset);
      write_reg(REG_QUIET_MAGNITUDE, qmag);
      write_reg(REG_QUIET_DEBOUNCE, deb);
      ph_onset    = onset;
      ph_quiet    = qmag;
      ph_debounce = deb;
   endtask

   // Random words in segments: quiet runs, loud bursts, noise and restarts
   task automatic run_random_phase(int unsigned n_words);
      int unsigned done;
      int unsigned pick;
      int unsigned seg_len;
      int unsigned base;
      int unsigned top;
      int unsigned mag;
      logic        steady;
      done = 0;
      while (done < n_words) begin
         pick   = $urandom_range(99);
         steady = ($urandom_range(3) == 0);
         if (pick < 45) begin
            seg_len = $urandom_range(3, (ph_debounce > 25) ? 30 : ph_debounce + 5);
         end else if (pick < 75) begin
            seg_len = $urandom_range(1, 6);
         end else if (pick < 92) begin
            seg_len = $urandom_range(1, 4);
         end else begin
            seg_len = 1;
         end
         base = $urandom_range((ph_quiet == 0) ? 0 : ph_quiet - 1);
         top  = ph_onset * 3 + 64;
         if (top > MAG_MAX) top = MAG_MAX;
         repeat (seg_len) begin
            if (pick < 45) begin
               mag = base + $urandom_range(3);
            end else if (pick < 75) begin
               mag = $urandom_range(ph_onset, top);
            end else begin
               mag = $urandom_range(MAG_MAX);
            end
            if (mag > MAG_MAX) mag = MAG_MAX;
            send_word(mag[SAMPLE_W-1:0], pick >= 92, steady ? 0 : pick_gap(), 1'b0, '0);
            done++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type rows [$];
      int unsigned  ph;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.magnitude = '0;
      req_ch.restart   = 1'b0;

      // window filling, extreme energies, restart, filling again after it
      rows.push_back('{ROW_SAMPLE, 16'd0,   1'b0, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b0, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      rows.push_back('{ROW_SAMPLE, 16'd0,   1'b0, REG_ENERGY_HIGH, 0, 1'b1,
                       '{TKEO_PEAK, 1'b1, 1'b1}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b0, REG_ENERGY_HIGH, 0, 1'b1,
                       '{-TKEO_PEAK, 1'b1, 1'b1}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b1, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b0, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b0, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      rows.push_back('{ROW_SAMPLE, MAG_MAX, 1'b0, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b1, 1'b1}});
      rows.push_back('{ROW_SAMPLE, 16'd0,   1'b1, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});
      // zero debounce, wide quiet band, writes to unused indexes
      rows.push_back('{ROW_WRITE, 16'd0, 1'b0, REG_QUIET_DEBOUNCE,  0,     1'b0, '0});
      rows.push_back('{ROW_WRITE, 16'd0, 1'b0, REG_QUIET_MAGNITUDE, 65535, 1'b0, '0});
      rows.push_back('{ROW_WRITE, 16'd0, 1'b0, REG_SPARE_LO,        -1,    1'b0, '0});
      rows.push_back('{ROW_WRITE, 16'd0, 1'b0, REG_SPARE_HI,        0,     1'b0, '0});
      // onset, loud, first quiet word, return to idle, onset again
      rows.push_back('{ROW_SAMPLE, 16'd100, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd100, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd100, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd900, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd900, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd900, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd900, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd900, 1'b0, REG_ENERGY_HIGH, 0, 1'b0, '0});
      rows.push_back('{ROW_SAMPLE, 16'd0,   1'b1, REG_ENERGY_HIGH, 0, 1'b1, '{33'sd0, 1'b0, 1'b0}});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            pause_stream();
            write_reg(rows[i].reg_idx, rows[i].reg_val);
         end else begin
            send_word(rows[i].mag, rows[i].restart, pick_gap(), rows[i].pinned, rows[i].want);
         end
      end

      // extreme settings, then the reset values, then random settings
      program_detector(TKEO_PEAK, -TKEO_PEAK, MAG_MAX, 0, MAG_MAX);
      run_random_phase(WORDS_PER_PHASE);
      program_detector(-TKEO_PEAK, TKEO_PEAK, 0, MAG_MAX, 0);
      run_random_phase(WORDS_PER_PHASE);
      program_detector(ENERGY_HIGH_RST, ENERGY_LOW_RST, ONSET_MAGNITUDE_RST,
                       QUIET_MAGNITUDE_RST, QUIET_DEBOUNCE_RST);
      run_random_phase(WORDS_PER_PHASE);
      for (ph = 0; ph < 4; ph++) begin
         program_detector($urandom_range(500, 300000),
                          longint'($urandom_range(6000)) - 1000,
                          $urandom_range(200, 4000),
                          $urandom_range(100, 1500),
                          $urandom_range(12));
         run_random_phase(WORDS_PER_PHASE);
      end

      // drain and let the pipeline settle
      pause_stream();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule : tkeo_hysteresis_disturbance_detector_top_test
